FILE: design/linear_interp_resampler_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// Implication checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LIR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LIR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Widths, constants and shared types of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 19;
  localparam int MAX_BLOCK   = 65536;
  localparam int K_W         = $clog2(MAX_BLOCK);
  localparam int MAX_RATIO   = 8;
  localparam int MAX_RESULTS = 2 * MAX_RATIO + 1;
  localparam int RUN_W       = $clog2(MAX_RESULTS + 1);

  // Output count and source positions stay below 2^36 for any rate pair.
  localparam int OC_W      = 36;
  localparam int POS_SPLIT = OC_W / 2;

  // Shared serial divider: 36-bit dividend, divisor up to twice a rate.
  localparam int DIVD_W    = OC_W;
  localparam int DIVS_W    = RATE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [RATE_W-1:0] IN_RATE_RESET  = RATE_W'(16000);
  localparam logic [RATE_W-1:0] OUT_RATE_RESET = RATE_W'(48000);

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IN_RATE  = 1'b0,
    REG_OUT_RATE = 1'b1
  } cfg_reg_t;

  // One classified input sample waiting for the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [SAMPLE_W-1:0] prev;
    logic [K_W-1:0]             k;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TGT_MUL,
    S_TGT_START,
    S_TGT_WAIT,
    S_COUNT,
    S_POS_LO,
    S_POS_HI,
    S_POS_SUM,
    S_POS_START,
    S_POS_WAIT,
    S_INT_MUL,
    S_INT_SUM,
    S_INT_START,
    S_INT_WAIT,
    S_EMIT
  } back_state_t;

endpackage

FILE: design/lir_channels.sv
// ----------------------------------------------------------------------------
// lir_channels
// Valid/ready channels for input samples and output results.
// ----------------------------------------------------------------------------
interface lir_in_if;
  import lir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       block_last;

  modport source (output valid, sample_in, block_last, input ready);
  modport sink   (input valid, sample_in, block_last, output ready);
endinterface

interface lir_out_if;
  import lir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       run_last;
  logic                       block_done;
  logic                       overflow;

  modport source (output valid, sample_out, run_last, block_done, overflow, input ready);
  modport sink   (input valid, sample_out, run_last, block_done, overflow, output ready);
endinterface

FILE: design/linear_interp_resampler_top.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Linear interpolation sample rate converter for signed 16-bit mono blocks.
// Input samples arrive on in_ch (sample_in, block_last); results leave on
// out_ch (sample_out, run_last, block_done, overflow), both valid/ready.
// in_rate and out_rate are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. A zero rate turns output off. Each input transaction
// yields zero to seventeen result transactions. Per input, the output count
// is worked out by one division; each result then takes one division for its
// position when it copies the sample and a second when it interpolates. All
// divisions run on the shared serial divider, which resolves one quotient bit
// per cycle over a 36-bit dividend.
// Two samples can wait in the queue, so the input keeps accepting while the
// back end works, and the output register holds a result while the receiver
// stalls; the back end then waits until it is taken.
// Synchronous reset restores 16000/48000 Hz and starts a new block.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_top_assert.svh"

module linear_interp_resampler_top (
  input  logic                       clk,
  input  logic                       rst,
  lir_in_if.sink                     in_ch,
  lir_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [lir_pkg::RATE_W-1:0] cfg_data
);
  import lir_pkg::*;

  logic [RATE_W-1:0] in_rate;
  logic [RATE_W-1:0] out_rate;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  job_t     q_in;
  job_t     q_out;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Rate registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_rate  <= IN_RATE_RESET;
      out_rate <= OUT_RATE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_IN_RATE) begin
        in_rate <= cfg_data;
      end else begin
        out_rate <= cfg_data;
      end
    end
  end

  lir_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  lir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  lir_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lir_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_rate  (in_rate),
    .out_rate (out_rate),
    .q_empty  (q_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .out_ch   (out_ch)
  );

  // The queue is never written while full nor read while empty.
  `LIR_ASSERT_IMPL(a_queue_push_room, q_push, !q_full, "job pushed into a full queue")
  `LIR_ASSERT_IMPL(a_queue_pop_data, q_pop, !q_empty, "job popped from an empty queue")
  // A division is only started once the previous one has finished.
  `LIR_ASSERT_IMPL(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  // The block's final result is also the last result of its sample.
  `LIR_ASSERT_IMPL(a_done_on_run_last, out_ch.valid && out_ch.block_done, out_ch.run_last,
                   "block_done without run_last")
  // A finished division always returns a busy divider to idle.
  `LIR_ASSERT_NEXT(a_div_done_idle, div_rsp.done && !div_req.start, !div_rsp.busy,
                   "divider busy after completion")

endmodule

FILE: design/lir_front.sv
// ----------------------------------------------------------------------------
// lir_front
// Accepts input samples, tracks the position within the block, and queues
// each sample with its predecessor and block-end flag for the back end.
// ----------------------------------------------------------------------------
module lir_front (
  input  logic          clk,
  input  logic          rst,
  lir_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output lir_pkg::job_t q_data
);
  import lir_pkg::*;

  logic signed [SAMPLE_W-1:0] prev_sample;
  logic [K_W-1:0]             input_count;
  logic                       is_last;

  // A sample is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // The block also ends when the sample count reaches its limit.
  assign is_last = in_ch.block_last || (input_count == K_W'(MAX_BLOCK - 1));

  assign q_data = '{cur: in_ch.sample_in, prev: prev_sample, k: input_count, last: is_last};

  // Block position and previous sample; both restart after a block end.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      input_count <= '0;
    end else if (q_push) begin
      if (is_last) begin
        prev_sample <= '0;
        input_count <= '0;
      end else begin
        prev_sample <= in_ch.sample_in;
        input_count <= input_count + 1'b1;
      end
    end
  end

endmodule

FILE: design/lir_queue.sv
// ----------------------------------------------------------------------------
// lir_queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module lir_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lir_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output lir_pkg::job_t pop_data,
  output logic          empty
);
  import lir_pkg::*;

  job_t               entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   fill;

  assign full     = (fill == (Q_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: design/lir_div.sv
// ----------------------------------------------------------------------------
// lir_div
// Restoring serial divider: one quotient bit per cycle, shared by all
// divisions of the back end. Quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module lir_div (
  input  logic              clk,
  input  logic              rst,
  input  lir_pkg::div_req_t req,
  output lir_pkg::div_rsp_t rsp
);
  import lir_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] steps_left;
  logic [DIVD_W-1:0]    shreg;
  logic [DIVS_W-1:0]    partial;
  logic [DIVS_W-1:0]    divisor;
  logic [DIVS_W:0]      trial;
  logic                 fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {partial, shreg[DIVD_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  assign rsp = '{busy: busy, done: done, quot: shreg, rem: partial};

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy       <= 1'b1;
        steps_left <= DIV_CNT_W'(DIVD_W);
      end else if (busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg   <= req.dividend;
      partial <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      shreg <= {shreg[DIVD_W-2:0], fits};
      if (fits) begin
        partial <= DIVS_W'(trial - {1'b0, divisor});
      end else begin
        partial <= trial[DIVS_W-1:0];
      end
    end
  end

endmodule

FILE: design/lir_back.sv
// ----------------------------------------------------------------------------
// lir_back
// Takes queued samples, works out how many outputs fall before each one,
// and produces them one at a time: position by division, then either a copy
// of the sample or interpolation, rounding and saturation, into the output register.
// ----------------------------------------------------------------------------
module lir_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lir_pkg::RATE_W-1:0] in_rate,
  input  logic [lir_pkg::RATE_W-1:0] out_rate,
  input  logic                      q_empty,
  input  lir_pkg::job_t             q_data,
  output logic                      q_pop,
  output lir_pkg::div_req_t         div_req,
  input  lir_pkg::div_rsp_t         div_rsp,
  lir_out_if.source                 out_ch
);
  import lir_pkg::*;

  localparam int PROD_W = K_W + 1 + RATE_W;
  localparam int PART_W = POS_SPLIT + RATE_W;
  localparam int M1_W   = SAMPLE_W + RATE_W + 1;
  localparam int M2_W   = RATE_W + 1 + SAMPLE_W + 1;
  localparam int NUM_W  = M2_W + 1;

  back_state_t state;
  back_state_t state_next;

  // Control registers.
  logic [OC_W-1:0] output_count;
  logic            out_valid;

  // Per-sample and per-output working registers.
  job_t                       job;
  logic [PROD_W-1:0]          prod;
  logic [OC_W-1:0]            target;
  logic [OC_W-1:0]            idx;
  logic [RUN_W-1:0]           n_left;
  logic                       dropped;
  logic [PART_W-1:0]          plo;
  logic [PART_W-1:0]          phi;
  logic [OC_W-1:0]            pos;
  logic [RATE_W-1:0]          frac;
  logic signed [M1_W-1:0]     m1;
  logic signed [M2_W-1:0]     m2;
  logic signed [NUM_W-1:0]    num;
  logic                       neg;
  logic signed [SAMPLE_W-1:0] val;

  // Output register.
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_run_last;
  logic                       out_block_done;
  logic                       out_overflow;

  // Combinational helpers.
  logic                        rates_on;
  logic                        out_load;
  logic [K_W:0]                kk;
  logic [PROD_W-1:0]           tgt_prod;
  logic [OC_W:0]               diff;
  logic                        gt;
  logic                        whole_ge_k;
  logic signed [SAMPLE_W:0]    step;
  logic [NUM_W-1:0]            mag;
  logic [PART_W-1:0]           plo_prod;
  logic [PART_W-1:0]           phi_prod;
  logic signed [M1_W-1:0]      m1_prod;
  logic signed [M2_W-1:0]      m2_prod;

  // Round-to-nearest quotient back to a signed sample, clipped to range.
  function automatic logic signed [SAMPLE_W-1:0] sat_q(input logic neg_in,
                                                      input logic [DIVD_W-1:0] q);
    logic signed [SAMPLE_W-1:0] r;
    if (neg_in) begin
      r = (q >= DIVD_W'(32768)) ? SAT_MIN : -$signed(q[SAMPLE_W-1:0]);
    end else begin
      r = (q >= DIVD_W'(32767)) ? SAT_MAX : $signed(q[SAMPLE_W-1:0]);
    end
    return r;
  endfunction

  assign rates_on = (in_rate != '0) && (out_rate != '0);
  assign out_load = (state == S_EMIT) && (!out_valid || out_ch.ready);

  // Count of outputs due: ceil(k*out/in), or the rounded block length at its end.
  assign kk       = job.last ? {1'b0, job.k} + 1'b1 : {1'b0, job.k};
  assign tgt_prod = kk * out_rate;
  assign diff     = {1'b0, target} - {1'b0, output_count};
  assign gt       = !diff[OC_W] && (diff != '0);

  // Source position of the output: i*in_rate in two half-width products.
  assign plo_prod = idx[POS_SPLIT-1:0] * in_rate;
  assign phi_prod = idx[OC_W-1:POS_SPLIT] * in_rate;

  // Interpolation numerator: prev*out_rate + remainder*(cur - prev).
  assign whole_ge_k = (div_rsp.quot >= OC_W'(job.k));
  assign step       = (SAMPLE_W + 1)'(job.cur) - (SAMPLE_W + 1)'(job.prev);
  assign m1_prod    = job.prev * $signed({1'b0, out_rate});
  assign m2_prod    = $signed({1'b0, frac}) * step;
  assign mag        = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and divider requests.
  always_comb begin
    state_next       = state;
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = pos;
    div_req.divisor  = {1'b0, out_rate};
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = rates_on ? S_TGT_MUL : S_IDLE;
        end
      end
      S_TGT_MUL: begin
        state_next = S_TGT_START;
      end
      S_TGT_START: begin
        div_req.start = 1'b1;
        if (job.last) begin
          div_req.dividend = DIVD_W'({prod, 1'b0} + in_rate);
          div_req.divisor  = {in_rate, 1'b0};
        end else begin
          div_req.dividend = DIVD_W'(prod + in_rate - 1'b1);
          div_req.divisor  = {1'b0, in_rate};
        end
        state_next = S_TGT_WAIT;
      end
      S_TGT_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        state_next = gt ? S_POS_LO : S_IDLE;
      end
      S_POS_LO: begin
        state_next = S_POS_HI;
      end
      S_POS_HI: begin
        state_next = S_POS_SUM;
      end
      S_POS_SUM: begin
        state_next = S_POS_START;
      end
      S_POS_START: begin
        div_req.start = 1'b1;
        state_next    = S_POS_WAIT;
      end
      S_POS_WAIT: begin
        if (div_rsp.done) begin
          state_next = whole_ge_k ? S_EMIT : S_INT_MUL;
        end
      end
      S_INT_MUL: begin
        state_next = S_INT_SUM;
      end
      S_INT_SUM: begin
        state_next = S_INT_START;
      end
      S_INT_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'({mag, 1'b0} + out_rate);
        div_req.divisor  = {out_rate, 1'b0};
        state_next       = S_INT_WAIT;
      end
      S_INT_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = (n_left == RUN_W'(1)) ? S_IDLE : S_POS_START;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Block output count and output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_IDLE && !q_empty && !rates_on && q_data.last) begin
        output_count <= '0;
      end else if (state == S_COUNT) begin
        if (job.last) begin
          output_count <= '0;
        end else if (gt) begin
          output_count <= target;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current sample and output.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          job <= q_data;
        end
      end
      S_TGT_MUL: begin
        prod <= tgt_prod;
      end
      S_TGT_WAIT: begin
        if (div_rsp.done) begin
          target <= div_rsp.quot;
        end
      end
      S_COUNT: begin
        idx     <= output_count;
        dropped <= (diff > (OC_W + 1)'(MAX_RESULTS));
        n_left  <= (diff > (OC_W + 1)'(MAX_RESULTS)) ? RUN_W'(MAX_RESULTS)
                                                      : diff[RUN_W-1:0];
      end
      S_POS_LO: begin
        plo <= plo_prod;
      end
      S_POS_HI: begin
        phi <= phi_prod;
      end
      S_POS_SUM: begin
        pos <= OC_W'(plo + {phi, POS_SPLIT'(0)});
      end
      S_POS_WAIT: begin
        if (div_rsp.done) begin
          frac <= div_rsp.rem[RATE_W-1:0];
          val  <= job.cur;
        end
      end
      S_INT_MUL: begin
        m1 <= m1_prod;
        m2 <= m2_prod;
      end
      S_INT_SUM: begin
        num <= NUM_W'(m1) + NUM_W'(m2);
      end
      S_INT_START: begin
        neg <= num[NUM_W-1];
      end
      S_INT_WAIT: begin
        if (div_rsp.done) begin
          val <= sat_q(neg, div_rsp.quot);
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_sample     <= val;
          out_run_last   <= (n_left == RUN_W'(1));
          out_block_done <= (n_left == RUN_W'(1)) && job.last;
          out_overflow   <= dropped;
          n_left         <= n_left - 1'b1;
          pos            <= OC_W'(pos + in_rate);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;
  assign out_ch.run_last   = out_run_last;
  assign out_ch.block_done = out_block_done;
  assign out_ch.overflow   = out_overflow;

endmodule
